// ===== hw/rtl/perfe_pkg.sv =====
// perfe_pkg: shared types and constants of the page entry range flag engine
// command codes, entry flag bits and fixed field widths; no dependencies
package perfe_pkg;

    // fixed field widths
    localparam int PAGE_W      = 12;
    localparam int REG_W       = 13;
    localparam int CMD_W       = 4;
    localparam int ENTRY_W     = 64;
    localparam int FRAME_IN_W  = 40;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USER_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_HIGH = 1'd1;

    // configuration reset values
    localparam logic [REG_W-1:0] USER_LOW_RST  = 13'd1024;
    localparam logic [REG_W-1:0] USER_HIGH_RST = 13'd4096;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_READ       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_USER_RW    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_USER_RO    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_USER_EXEC  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_KERNEL     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ADD_W      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLR_NX     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLR_AD     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CNT_DIRTY  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CNT_ACC    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MARK_DIRTY = 4'd11;
    localparam logic [CMD_W-1:0] CMD_MARK       = 4'd12;
    localparam logic [CMD_W-1:0] CMD_CLR_MARKED = 4'd13;
    localparam logic [CMD_W-1:0] CMD_MAP_UC     = 4'd14;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 4'd15;

    // x86-64 entry flag bits
    localparam logic [ENTRY_W-1:0] F_P   = 64'h1;
    localparam logic [ENTRY_W-1:0] F_W   = 64'h2;
    localparam logic [ENTRY_W-1:0] F_U   = 64'h4;
    localparam logic [ENTRY_W-1:0] F_PWT = 64'h8;
    localparam logic [ENTRY_W-1:0] F_PCD = 64'h10;
    localparam logic [ENTRY_W-1:0] F_A   = 64'h20;
    localparam logic [ENTRY_W-1:0] F_D   = 64'h40;
    localparam logic [ENTRY_W-1:0] F_MRK = 64'h200;
    localparam logic [ENTRY_W-1:0] F_NX  = 64'h8000_0000_0000_0000;
    localparam logic [ENTRY_W-1:0] KEEP_MASK = 64'h7FFF_FFFF_FFFF_FE00;

    // frame field starts above the page offset
    localparam int FRAME_SHIFT = 12;

    // saturating page count limit
    localparam logic [PAGE_W-1:0] CNT_MAX = 12'hFFF;

    // result of one entry update
    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic               hit;
    } t_alu_res;

endpackage

// ===== hw/rtl/perfe_store.sv =====
// perfe_store: single-port-write, single-port-read entry memory
// registered read port; uses perfe_pkg for the entry width
module perfe_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [perfe_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [perfe_pkg::ENTRY_W-1:0] o_rdata
);

    logic [perfe_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [perfe_pkg::ENTRY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/perfe_reduce.sv =====
// perfe_reduce: reduces two page indices modulo the store depth
// reciprocal multiply for the quotient, then one subtract; uses perfe_pkg
module perfe_reduce #(
    parameter int MODULUS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [perfe_pkg::PAGE_W-1:0] i_a,
    input  logic [perfe_pkg::PAGE_W-1:0] i_b,
    output logic                        o_done,
    output logic [perfe_pkg::PAGE_W-1:0] o_a,
    output logic [perfe_pkg::PAGE_W-1:0] o_b
);

    // a modulus at or above the index range leaves indices unchanged
    localparam bit PASS_THROUGH = (MODULUS >= (1 << perfe_pkg::PAGE_W));
    // rounded-up reciprocal, gives the exact quotient for any index below 2^PAGE_W
    localparam int RECIP_SHIFT = 2 * perfe_pkg::PAGE_W;
    localparam int PROD_W      = 3 * perfe_pkg::PAGE_W;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'(((1 << RECIP_SHIFT) + MODULUS - 1) / MODULUS);
    localparam logic [perfe_pkg::PAGE_W-1:0] MOD_LOW = perfe_pkg::PAGE_W'(MODULUS);

    logic                         r_busy;
    logic                         r_step;
    logic                         r_done;
    logic [perfe_pkg::PAGE_W-1:0] r_a;
    logic [perfe_pkg::PAGE_W-1:0] r_b;
    logic [perfe_pkg::PAGE_W-1:0] r_qa;
    logic [perfe_pkg::PAGE_W-1:0] r_qb;
    logic [perfe_pkg::PAGE_W-1:0] n_a;
    logic [perfe_pkg::PAGE_W-1:0] n_b;
    logic [PROD_W-1:0]            w_prod_a;
    logic [PROD_W-1:0]            w_prod_b;
    logic [perfe_pkg::PAGE_W-1:0] w_qm_a;
    logic [perfe_pkg::PAGE_W-1:0] w_qm_b;

    // quotient estimate by reciprocal multiplication
    assign w_prod_a = PROD_W'(r_a) * PROD_W'(RECIP);
    assign w_prod_b = PROD_W'(r_b) * PROD_W'(RECIP);

    // remainder only needs the low bits of quotient times modulus
    assign w_qm_a = r_qa * MOD_LOW;
    assign w_qm_b = r_qb * MOD_LOW;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (!PASS_THROUGH) begin
            n_a = r_a - w_qm_a;
            n_b = r_b - w_qm_b;
        end
    end

    // step control: quotient step, then remainder step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 1'b0;
            end else if (r_busy) begin
                if (!r_step) begin
                    r_step <= 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_step <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy && !r_step) begin
            r_qa <= w_prod_a[PROD_W-1:RECIP_SHIFT];
            r_qb <= w_prod_b[PROD_W-1:RECIP_SHIFT];
        end else if (r_busy) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_done = r_done;
    assign o_a    = r_a;
    assign o_b    = r_b;

endmodule

// ===== hw/rtl/perfe_entry_alu.sv =====
// perfe_entry_alu: per-entry update and hit flag for range commands
// combinational; uses perfe_pkg command codes and flag bits
module perfe_entry_alu (
    input  logic [perfe_pkg::CMD_W-1:0]   i_cmd,
    input  logic [perfe_pkg::ENTRY_W-1:0] i_entry,
    input  logic [perfe_pkg::ENTRY_W-1:0] i_map_entry,
    output perfe_pkg::t_alu_res          o_res
);

    logic [perfe_pkg::ENTRY_W-1:0] w_keep;

    assign w_keep = i_entry & perfe_pkg::KEEP_MASK;

    // new entry value and count hit by command
    always_comb begin
        o_res.entry = i_entry;
        o_res.hit   = 1'b0;
        case (i_cmd)
            perfe_pkg::CMD_USER_RW: begin
                o_res.entry = w_keep | perfe_pkg::F_P | perfe_pkg::F_U
                            | perfe_pkg::F_W | perfe_pkg::F_NX;
            end
            perfe_pkg::CMD_USER_RO: begin
                o_res.entry = w_keep | perfe_pkg::F_P | perfe_pkg::F_U | perfe_pkg::F_NX;
            end
            perfe_pkg::CMD_USER_EXEC: begin
                o_res.entry = w_keep | perfe_pkg::F_P | perfe_pkg::F_U;
            end
            perfe_pkg::CMD_KERNEL: begin
                o_res.entry = w_keep | perfe_pkg::F_P | perfe_pkg::F_W;
            end
            perfe_pkg::CMD_ADD_W: begin
                o_res.entry = i_entry | perfe_pkg::F_W;
            end
            perfe_pkg::CMD_CLR_NX: begin
                o_res.entry = i_entry & ~perfe_pkg::F_NX;
            end
            perfe_pkg::CMD_CLR_AD: begin
                o_res.entry = i_entry & ~(perfe_pkg::F_A | perfe_pkg::F_D);
            end
            perfe_pkg::CMD_CNT_DIRTY: begin
                o_res.hit = |(i_entry & perfe_pkg::F_D);
            end
            perfe_pkg::CMD_CNT_ACC: begin
                o_res.hit = |(i_entry & perfe_pkg::F_A);
            end
            perfe_pkg::CMD_MARK_DIRTY: begin
                if (|(i_entry & perfe_pkg::F_D)) begin
                    o_res.entry = i_entry | perfe_pkg::F_MRK;
                end
            end
            perfe_pkg::CMD_MARK: begin
                o_res.entry = i_entry | perfe_pkg::F_MRK;
            end
            perfe_pkg::CMD_CLR_MARKED: begin
                if (|(i_entry & perfe_pkg::F_MRK)) begin
                    o_res.entry = i_entry & ~(perfe_pkg::F_D | perfe_pkg::F_MRK);
                    o_res.hit   = 1'b1;
                end
            end
            perfe_pkg::CMD_MAP_UC: begin
                o_res.entry = i_map_entry;
            end
            default: begin
                o_res.entry = i_entry;
                o_res.hit   = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/page_entry_range_flag_engine.sv =====
// Page entry range flag engine: a store of ENTRY_COUNT x86-64 last-level page
// table entries with commands that read, write, recode, count or check entries
// one at a time or over a wrapping page range [first, end). One command is in
// flight at a time. After accepting a command the engine reduces the page
// indices modulo the store depth by reciprocal multiplication, then walks
// the range at one entry per cycle, set by the single read and write port
// of the entry memory; a stalled result holds the engine until it is taken.
// After reset a clearing pass zeroes the store, during which no command is
// accepted; configuration writes are taken at any time.
// Depends on perfe_pkg, perfe_store, perfe_reduce and perfe_entry_alu.
module page_entry_range_flag_engine #(
    parameter int ENTRY_COUNT = 4096,
    parameter int FRAME_BITS  = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [perfe_pkg::CMD_W-1:0]        i_command,
    input  logic [perfe_pkg::PAGE_W-1:0]       i_first_page,
    input  logic [perfe_pkg::PAGE_W-1:0]       i_end_page,
    input  logic [perfe_pkg::ENTRY_W-1:0]      i_entry_value,
    input  logic [perfe_pkg::FRAME_IN_W-1:0]   i_frame_number,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [perfe_pkg::ENTRY_W-1:0]      o_read_data,
    output logic [perfe_pkg::PAGE_W-1:0]       o_page_count,
    output logic                              o_check_ok,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [perfe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [perfe_pkg::REG_W-1:0]        i_cfg_data
);

    localparam int IDX_W = $clog2(ENTRY_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [IDX_W-1:0]                 r_clr_idx;
    logic [perfe_pkg::REG_W-1:0]      r_user_low;
    logic [perfe_pkg::REG_W-1:0]      r_user_high;

    // latched command
    logic [perfe_pkg::CMD_W-1:0]      r_cmd;
    logic [perfe_pkg::PAGE_W-1:0]     r_first;
    logic [perfe_pkg::ENTRY_W-1:0]    r_entry_value;
    logic [FRAME_BITS-1:0]            r_frame;

    // walk pointers and accumulators
    logic [IDX_W-1:0]                 r_idx;
    logic [IDX_W-1:0]                 r_wr_idx;
    logic [IDX_W-1:0]                 r_stop;
    logic [perfe_pkg::ENTRY_W-1:0]    r_rd;
    logic [perfe_pkg::PAGE_W-1:0]     r_cnt;
    logic                             r_ok;

    // result register
    logic                             r_out_valid;
    logic [perfe_pkg::ENTRY_W-1:0]    r_out_rd;
    logic [perfe_pkg::PAGE_W-1:0]     r_out_cnt;
    logic                             r_out_ok;

    logic                             w_in_acc;
    logic                             w_out_free;
    logic                             w_red_done;
    logic [perfe_pkg::PAGE_W-1:0]     w_red_a;
    logic [perfe_pkg::PAGE_W-1:0]     w_red_b;
    logic [31:0]                      w_red_a32;
    logic [31:0]                      w_red_b32;
    logic [IDX_W-1:0]                 w_start_idx;
    logic [IDX_W-1:0]                 w_stop_idx;
    logic [perfe_pkg::ENTRY_W-1:0]    w_frame_in64;
    logic [perfe_pkg::ENTRY_W-1:0]    w_frame64;
    logic [perfe_pkg::ENTRY_W-1:0]    w_map_entry;
    logic                             w_is_range;
    logic                             w_check_pass;
    perfe_pkg::t_alu_res              w_alu;

    // memory port
    logic                             w_mem_we;
    logic [IDX_W-1:0]                 w_mem_waddr;
    logic [perfe_pkg::ENTRY_W-1:0]    w_mem_wdata;
    logic                             w_mem_re;
    logic [IDX_W-1:0]                 w_mem_raddr;
    logic [perfe_pkg::ENTRY_W-1:0]    w_mem_rdata;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx);
        f_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // handshakes
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // index reduction unit
    perfe_reduce #(
        .MODULUS (ENTRY_COUNT)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_a     (i_first_page),
        .i_b     (i_end_page),
        .o_done  (w_red_done),
        .o_a     (w_red_a),
        .o_b     (w_red_b)
    );

    assign w_red_a32   = 32'(w_red_a);
    assign w_red_b32   = 32'(w_red_b);
    assign w_start_idx = w_red_a32[IDX_W-1:0];
    assign w_stop_idx  = w_red_b32[IDX_W-1:0];

    // uncached mapping entry for the current frame
    assign w_frame_in64 = 64'(i_frame_number);
    assign w_frame64    = 64'(r_frame);
    assign w_map_entry  = (w_frame64 << perfe_pkg::FRAME_SHIFT) | perfe_pkg::F_P
                        | perfe_pkg::F_W | perfe_pkg::F_PCD | perfe_pkg::F_PWT;

    assign w_is_range = (r_cmd != perfe_pkg::CMD_WRITE) && (r_cmd != perfe_pkg::CMD_READ)
                     && (r_cmd != perfe_pkg::CMD_CHECK);

    // user bounds and permission check on the addressed entry
    assign w_check_pass = (perfe_pkg::REG_W'(r_first) >= r_user_low)
                       && (perfe_pkg::REG_W'(r_first) < r_user_high)
                       && ((w_mem_rdata & (perfe_pkg::F_U | perfe_pkg::F_W))
                           == (perfe_pkg::F_U | perfe_pkg::F_W));

    // entry update
    perfe_entry_alu u_alu (
        .i_cmd       (r_cmd),
        .i_entry     (w_mem_rdata),
        .i_map_entry (w_map_entry),
        .o_res       (w_alu)
    );

    // memory access and next state
    always_comb begin
        n_state     = r_state;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_wr_idx;
        w_mem_wdata = w_alu.entry;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_idx;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_idx;
                w_mem_wdata = '0;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (w_red_done) begin
                    w_mem_raddr = w_start_idx;
                    if (r_cmd == perfe_pkg::CMD_WRITE) begin
                        w_mem_we    = 1'b1;
                        w_mem_waddr = w_start_idx;
                        w_mem_wdata = r_entry_value;
                        n_state     = S_DONE;
                    end else if (!w_is_range) begin
                        w_mem_re = 1'b1;
                        n_state  = S_RDWAIT;
                    end else if (w_start_idx == w_stop_idx) begin
                        n_state = S_DONE;
                    end else begin
                        w_mem_re = 1'b1;
                        n_state  = S_WALK;
                    end
                end
            end
            S_RDWAIT: begin
                n_state = S_DONE;
            end
            S_WALK: begin
                w_mem_we = 1'b1;
                if (r_idx != r_stop) begin
                    w_mem_re = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry memory
    perfe_store #(
        .DEPTH  (ENTRY_COUNT),
        .ADDR_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_user_low  <= perfe_pkg::USER_LOW_RST;
            r_user_high <= perfe_pkg::USER_HIGH_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    perfe_pkg::CFG_USER_LOW:  r_user_low  <= i_cfg_data;
                    perfe_pkg::CFG_USER_HIGH: r_user_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // command datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd         <= i_command;
            r_first       <= i_first_page;
            r_entry_value <= i_entry_value;
            r_frame       <= w_frame_in64[FRAME_BITS-1:0];
            r_rd          <= '0;
            r_cnt         <= '0;
            r_ok          <= 1'b0;
        end
        if (r_state == S_REDUCE && w_red_done) begin
            r_stop   <= w_stop_idx;
            r_wr_idx <= w_start_idx;
            r_idx    <= f_next(w_start_idx);
        end
        if (r_state == S_RDWAIT) begin
            if (r_cmd == perfe_pkg::CMD_READ) begin
                r_rd <= w_mem_rdata;
            end else begin
                r_ok <= w_check_pass;
            end
        end
        if (r_state == S_WALK) begin
            r_frame  <= r_frame + 1'b1;
            r_wr_idx <= r_idx;
            r_idx    <= f_next(r_idx);
            if (w_alu.hit && r_cnt != perfe_pkg::CNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_rd  <= r_rd;
            r_out_cnt <= r_cnt;
            r_out_ok  <= r_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_rd;
    assign o_page_count = r_out_cnt;
    assign o_check_ok   = r_out_ok;

`ifndef ASSERT_OFF
    // the walk never writes the entry it is reading in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && w_mem_re) |-> (w_mem_waddr != w_mem_raddr))
        else $error("read and write to the same entry in one cycle");

    // every walk step consumes data of a read issued the cycle before
    a_walk_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> $past(w_mem_re))
        else $error("walk step without a pending read");

    // a result only appears when a transaction finishes
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside command completion");

    // no result while the store is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result valid during clearing pass");
`endif

endmodule

// ===== sim/pte_shadow_pkg.sv =====
// pte_shadow_pkg: shadow copy of the page entry store with result prediction and checking
// for the page entry range flag engine testbench; depends on perfe_pkg
package pte_shadow_pkg;
    import perfe_pkg::*;

    // page indices wrap in PAGE_W bits, so the store depth is 2**PAGE_W
    localparam int STORE_DEPTH = 4096;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [ENTRY_W-1:0] read_data;
        logic [PAGE_W-1:0]  page_count;
        logic               check_ok;
    } t_pte_result;

    class pte_shadow;
        logic [ENTRY_W-1:0] entries [STORE_DEPTH];
        logic [REG_W-1:0]   user_low;
        logic [REG_W-1:0]   user_high;
        t_pte_result        expected_results [$];
        int                 mismatches;
        int                 compared;

        function new();
            foreach (entries[i]) entries[i] = '0;
            user_low   = USER_LOW_RST;
            user_high  = USER_HIGH_RST;
            mismatches = 0;
            compared   = 0;
        endfunction

        // mirror of a bounds register write
        function void set_bound(logic [CFG_IDX_W-1:0] index, logic [REG_W-1:0] value);
            if (index == CFG_USER_LOW) begin
                user_low = value;
            end else begin
                user_high = value;
            end
        endfunction

        // apply one accepted transaction to the shadow store and queue its result
        function void note_command(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] first_page,
                                   logic [PAGE_W-1:0] end_page, logic [ENTRY_W-1:0] entry_value,
                                   logic [FRAME_IN_W-1:0] frame_number);
            logic [PAGE_W-1:0]     idx;
            logic [FRAME_IN_W-1:0] frame;
            logic [ENTRY_W-1:0]    e;
            logic                  hit;
            t_pte_result           res;
            idx   = first_page;
            frame = frame_number;
            res   = '0;
            case (cmd)
                CMD_WRITE: begin
                    entries[idx] = entry_value;
                end
                CMD_READ: begin
                    res.read_data = entries[idx];
                end
                CMD_CHECK: begin
                    // bounds use the page index before reduction
                    res.check_ok = ({1'b0, first_page} >= user_low) &&
                                   ({1'b0, first_page} < user_high) &&
                                   ((entries[idx] & (F_U | F_W)) == (F_U | F_W));
                end
                default: begin
                    // range walk, stops before end_page, wraps with the index width
                    while (idx != end_page) begin
                        e   = entries[idx];
                        hit = 1'b0;
                        case (cmd)
                            CMD_USER_RW:    e = (e & KEEP_MASK) | F_P | F_U | F_W | F_NX;
                            CMD_USER_RO:    e = (e & KEEP_MASK) | F_P | F_U | F_NX;
                            CMD_USER_EXEC:  e = (e & KEEP_MASK) | F_P | F_U;
                            CMD_KERNEL:     e = (e & KEEP_MASK) | F_P | F_W;
                            CMD_ADD_W:      e = e | F_W;
                            CMD_CLR_NX:     e = e & ~F_NX;
                            CMD_CLR_AD:     e = e & ~(F_A | F_D);
                            CMD_CNT_DIRTY:  hit = (e & F_D) != '0;
                            CMD_CNT_ACC:    hit = (e & F_A) != '0;
                            CMD_MARK_DIRTY: begin
                                if ((e & F_D) != '0) e = e | F_MRK;
                            end
                            CMD_MARK:       e = e | F_MRK;
                            CMD_CLR_MARKED: begin
                                if ((e & F_MRK) != '0) begin
                                    e   = e & ~(F_D | F_MRK);
                                    hit = 1'b1;
                                end
                            end
                            default: begin
                                // uncached mapping, frame wraps in its own width
                                e = ({{(ENTRY_W-FRAME_IN_W){1'b0}}, frame} << FRAME_SHIFT) |
                                    F_P | F_W | F_PCD | F_PWT;
                                frame = frame + 1'b1;
                            end
                        endcase
                        entries[idx] = e;
                        if (hit && res.page_count != CNT_MAX) res.page_count = res.page_count + 1'b1;
                        idx = idx + 1'b1;
                    end
                end
            endcase
            expected_results.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
        endtask

        // compare one accepted result transaction with the oldest prediction
        task check_result(logic [ENTRY_W-1:0] read_data, logic [PAGE_W-1:0] page_count,
                          logic check_ok);
            t_pte_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with none pending: read_data=%h page_count=%0d ok=%b",
                                 read_data, page_count, check_ok));
                return;
            end
            want = expected_results.pop_front();
            compared++;
            if (read_data !== want.read_data)
                report($sformatf("result %0d read_data %h, want %h",
                                 compared, read_data, want.read_data));
            if (page_count !== want.page_count)
                report($sformatf("result %0d page_count %0d, want %0d",
                                 compared, page_count, want.page_count));
            if (check_ok !== want.check_ok)
                report($sformatf("result %0d check_ok %b, want %b",
                                 compared, check_ok, want.check_ok));
        endtask
    endclass

endpackage

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench of the page entry range flag engine
// drives commands and bounds registers, checks results against pte_shadow_pkg; needs perfe_pkg
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import perfe_pkg::*;
    import pte_shadow_pkg::*;

    localparam int QUIET_LIMIT   = 25000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 29;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [CMD_W-1:0]      i_command      = CMD_READ;
    logic [PAGE_W-1:0]     i_first_page   = '0;
    logic [PAGE_W-1:0]     i_end_page     = '0;
    logic [ENTRY_W-1:0]    i_entry_value  = '0;
    logic [FRAME_IN_W-1:0] i_frame_number = '0;
    logic                  i_out_stall    = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_USER_LOW;
    logic [REG_W-1:0]      i_cfg_data     = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [ENTRY_W-1:0]    o_read_data;
    logic [PAGE_W-1:0]     o_page_count;
    logic                  o_check_ok;

    pte_shadow shadow;
    bit        idle_on = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    int        items_sent = 0;
    int        directed_items = 0;
    logic [PAGE_W-1:0] window_base = '0;

    page_entry_range_flag_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_first_page   (i_first_page),
        .i_end_page     (i_end_page),
        .i_entry_value  (i_entry_value),
        .i_frame_number (i_frame_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_page_count   (o_page_count),
        .o_check_ok     (o_check_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15);
        end
        if (!idle_on) stall_left = 0;
        i_out_stall <= (stall_left != 0);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            shadow.check_result(o_read_data, o_page_count, o_check_ok);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one command transaction, optionally after a random idle burst
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] first_page,
                                logic [PAGE_W-1:0] end_page, logic [ENTRY_W-1:0] value,
                                logic [FRAME_IN_W-1:0] frame);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_first_page   <= first_page;
        i_end_page     <= end_page;
        i_entry_value  <= value;
        i_frame_number <= frame;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        shadow.note_command(cmd, first_page, end_page, value, frame);
        items_sent++;
    endtask

    // hold the sender until every pending result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.expected_results.size() != 0);
    endtask

    // write both bounds registers back to back
    task automatic set_bounds(logic [REG_W-1:0] low, logic [REG_W-1:0] high);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_USER_LOW;
        i_cfg_data  <= low;
        @(posedge i_clk);
        shadow.set_bound(CFG_USER_LOW, low);
        i_cfg_index <= CFG_USER_HIGH;
        i_cfg_data  <= high;
        @(posedge i_clk);
        shadow.set_bound(CFG_USER_HIGH, high);
        i_cfg_we    <= 1'b0;
    endtask

    // page pick: bounds edges, a hot window so commands meet, or anywhere
    function automatic logic [PAGE_W-1:0] pick_page();
        int                sel;
        logic [REG_W-1:0]  edge_page;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            case ($urandom_range(0, 3))
                0:       edge_page = shadow.user_low - 1'b1;
                1:       edge_page = shadow.user_low;
                2:       edge_page = shadow.user_high - 1'b1;
                default: edge_page = shadow.user_high;
            endcase
            if (edge_page > REG_W'(STORE_DEPTH - 1)) edge_page = REG_W'($urandom_range(0, 4095));
            return edge_page[PAGE_W-1:0];
        end else if (sel < 75) begin
            return window_base + PAGE_W'($urandom_range(0, 63));
        end
        return PAGE_W'($urandom_range(0, 4095));
    endfunction

    // mostly short ranges, a few long walks
    function automatic logic [PAGE_W-1:0] pick_span();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return PAGE_W'($urandom_range(0, 24));
        if (sel < 95) return PAGE_W'($urandom_range(25, 300));
        return PAGE_W'($urandom_range(301, 4095));
    endfunction

    task automatic send_random_command();
        logic [CMD_W-1:0]      cmd;
        logic [PAGE_W-1:0]     first_page;
        logic [ENTRY_W-1:0]    value;
        logic [FRAME_IN_W-1:0] frame;
        cmd = CMD_W'($urandom_range(0, 15));
        if ($urandom_range(0, 4) == 0) cmd = CMD_WRITE;
        first_page = pick_page();
        value = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0) begin
            frame = '1 - FRAME_IN_W'($urandom_range(0, 8));
        end else begin
            frame = FRAME_IN_W'({$urandom, $urandom});
        end
        send_command(cmd, first_page, first_page + pick_span(), value, frame);
    endtask

    initial begin
        shadow = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single entries, reset bounds, wrapping and empty ranges
        send_command(CMD_WRITE, 12'd0, 12'd0, '1, '0);
        send_command(CMD_READ, 12'd0, 12'd0, '0, '0);
        send_command(CMD_WRITE, 12'd4095, 12'd0, F_NX | F_MRK | F_D | F_A | F_U | F_W | F_P, '0);
        send_command(CMD_WRITE, 12'd4094, 12'd0, F_D | F_A | F_U | F_W | F_P, '0);
        send_command(CMD_WRITE, 12'd1023, 12'd0, F_U | F_W, '0);
        send_command(CMD_CHECK, 12'd1023, 12'd0, '0, '0);
        send_command(CMD_WRITE, 12'd1024, 12'd0, F_U | F_W, '0);
        send_command(CMD_CHECK, 12'd1024, 12'd0, '0, '0);
        send_command(CMD_CHECK, 12'd4095, 12'd0, '0, '0);
        send_command(CMD_CNT_DIRTY, 12'd4094, 12'd2, '0, '0);
        send_command(CMD_CNT_ACC, 12'd4094, 12'd2, '0, '0);
        send_command(CMD_MARK_DIRTY, 12'd4094, 12'd2, '0, '0);
        send_command(CMD_CLR_MARKED, 12'd4094, 12'd3, '0, '0);
        send_command(CMD_USER_RW, 12'd4094, 12'd1, '0, '0);
        send_command(CMD_USER_RO, 12'd0, 12'd2, '0, '0);
        send_command(CMD_USER_EXEC, 12'd1023, 12'd1025, '0, '0);
        send_command(CMD_KERNEL, 12'd1024, 12'd1026, '0, '0);
        send_command(CMD_ADD_W, 12'd1022, 12'd1025, '0, '0);
        send_command(CMD_CLR_NX, 12'd4095, 12'd1, '0, '0);
        send_command(CMD_CLR_AD, 12'd4094, 12'd1, '0, '0);
        // empty ranges
        send_command(CMD_CNT_DIRTY, 12'd7, 12'd7, '0, '0);
        send_command(CMD_MARK, 12'd7, 12'd7, '0, '0);
        // frame wraps at the top of its width
        send_command(CMD_MAP_UC, 12'd100, 12'd104, '0, '1 - 1'b1);
        send_command(CMD_READ, 12'd102, 12'd0, '0, '0);
        // longest range, count reaches its limit
        send_command(CMD_MARK, 12'd5, 12'd4, '0, '0);
        send_command(CMD_CLR_MARKED, 12'd5, 12'd4, '0, '0);
        directed_items = items_sent;

        // random phases, bounds change only while idle
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       set_bounds(REG_W'(0), REG_W'(STORE_DEPTH));
                1:       set_bounds(REG_W'($urandom_range(0, 2048)),
                                    REG_W'($urandom_range(2048, 4096)));
                2:       set_bounds(REG_W'(STORE_DEPTH), REG_W'(0));
                default: set_bounds(REG_W'($urandom_range(0, 4096)),
                                    REG_W'($urandom_range(0, 4096)));
            endcase
            window_base = PAGE_W'($urandom_range(0, 4095));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_on = (phase != PHASES - 1) && (n % 30 < 22);
                send_random_command();
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d commands (%0d directed, rest random over %0d bounds settings)",
                 items_sent, directed_items, PHASES);
        $display("compared %0d results, %0d mismatches", shadow.compared, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/perfe_pkg.sv
hw/rtl/perfe_store.sv
hw/rtl/perfe_reduce.sv
hw/rtl/perfe_entry_alu.sv
hw/rtl/page_entry_range_flag_engine.sv
sim/pte_shadow_pkg.sv
sim/tb_top.sv
